@@ rtl/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, register codes and reciprocal table shared by the box blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // one window column, index 0 is the upper row
  typedef pix_t [2:0] pcol_t;

  // one step of the window, handed from the front end to the averaging pipe
  typedef struct packed {
    logic          load;
    logic          last;
    logic [2:0]    col_ok;
    logic [2:0]    row_ok;
    pcol_t [2:0]   win;
  } adv_t;

  typedef enum logic {
    REG_IMG_WIDTH  = 1'b0,
    REG_IMG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam int         WIDTH_BITS  = 11;
  localparam int         HEIGHT_BITS = 13;
  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd768;

  localparam int SUM_BITS    = 12;
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 16;

  // ceil(2^16 / n); exact for every rounded sum a 3x3 window can reach
  function automatic logic [16:0] recip(input logic [3:0] cnt);
    logic [16:0] k;
    case (cnt)
      4'd2:    k = 17'd32768;
      4'd3:    k = 17'd21846;
      4'd4:    k = 17'd16384;
      4'd6:    k = 17'd10923;
      4'd9:    k = 17'd7282;
      default: k = 17'd65536;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/box_blur_3x3.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3: one beat per cycle while in_stall is low; stage 1 and then the output
// register take a result once its window completes, img_width+1 beats behind its pixel.
// Single-row frames hold in_stall for one cycle after the last pixel (line-store port).
// Reset: rst_n (sync, low) clears positions, window and valids; line store not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_end
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic          restart;
  logic [WW-1:0] eff_width;
  logic [HW-1:0] eff_height;
  logic          s1_free;
  bb3_pkg::adv_t adv;

  bb3_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .restart     (restart),
    .eff_width   (eff_width),
    .eff_height  (eff_height)
  );

  bb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .s1_free     (s1_free),
    .adv         (adv)
  );

  bb3_avg u_avg (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .s1_free       (s1_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ rtl/bb3_ram.sv @@
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bb3_cfg.sv @@
// ----------------------------------------------------------------------------
// bb3_cfg
// APB register file for frame size; clamps values and flags a frame restart.
// ----------------------------------------------------------------------------
module bb3_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output logic          restart,
  output logic [WW-1:0] eff_width,
  output logic [HW-1:0] eff_height
);

  logic [bb3_pkg::WIDTH_BITS-1:0]  img_width_r;
  logic [bb3_pkg::HEIGHT_BITS-1:0] img_height_r;
  bb3_pkg::reg_idx_t               reg_sel;
  logic                            wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = bb3_pkg::reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign restart    = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= bb3_pkg::WIDTH_RST;
      img_height_r <= bb3_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bb3_pkg::REG_IMG_WIDTH:  img_width_r  <= cfg_pwdata[bb3_pkg::WIDTH_BITS-1:0];
        bb3_pkg::REG_IMG_HEIGHT: img_height_r <= cfg_pwdata[bb3_pkg::HEIGHT_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bb3_pkg::REG_IMG_WIDTH:  cfg_prdata = 32'(img_width_r);
      bb3_pkg::REG_IMG_HEIGHT: cfg_prdata = 32'(img_height_r);
    endcase
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (img_width_r == '0) begin
      eff_width = WW'(1);
    end else if (32'(img_width_r) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(img_width_r);
    end
    if (img_height_r == '0) begin
      eff_height = HW'(1);
    end else if (32'(img_height_r) > MAX_HEIGHT) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = HW'(img_height_r);
    end
  end

endmodule

@@ rtl/bb3_front.sv @@
// ----------------------------------------------------------------------------
// bb3_front
// Position counters, two-row line store and the 3x3 window shift.
// ----------------------------------------------------------------------------
module bb3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  logic [WW-1:0]       eff_width,
  input  logic [HW-1:0]       eff_height,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic                s1_free,
  output bb3_pkg::adv_t       adv
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int LW = 2 * $bits(bb3_pkg::pix_t);

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  bb3_pkg::pcol_t [2:0] win_r, win_nxt, win_step;

  logic          byp_r, byp_nxt;
  logic [LW-1:0] byp_data_r;
  logic [LW-1:0] ram_rdata, line_rd, ram_wdata;
  logic          ram_we;

  bb3_pkg::pix_t px, up_px, mid_px;

  logic drain, due, skip, item_acc, step;
  logic in_col_wrap, out_col_wrap, last_row, frame_last;

  // line store: {upper, middle} per column, read ahead at the next position
  bb3_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col_r),
    .wdata (ram_wdata),
    .raddr (in_col_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    drain = 32'(in_row_r) >= 32'(eff_height);
    due   = (32'(in_row_r) >= 32'd2) || ((32'(in_row_r) == 32'd1) && (in_col_r != '0));
    // single-row frame: step the one position that yields nothing on our own
    skip     = drain && !due;
    in_stall = skip || !s1_free;
    item_acc = in_valid && !in_stall;
    step     = skip || (item_acc && (drain || !in_req_type));

    px      = drain ? '0 : bb3_pkg::pix_t'({in_red, in_green, in_blue});
    line_rd = byp_r ? byp_data_r : ram_rdata;
    up_px   = line_rd[LW-1:LW/2];
    mid_px  = line_rd[LW/2-1:0];

    win_step[0]    = win_r[1];
    win_step[1]    = win_r[2];
    win_step[2][0] = up_px;
    win_step[2][1] = mid_px;
    win_step[2][2] = px;

    ram_we    = step;
    ram_wdata = {mid_px, px};

    in_col_wrap  = (32'(in_col_r) + 32'd1) >= 32'(eff_width);
    out_col_wrap = (32'(out_col_r) + 32'd1) >= 32'(eff_width);
    last_row     = (32'(out_row_r) + 32'd1) >= 32'(eff_height);
    frame_last   = step && due && last_row && out_col_wrap;

    adv.load   = step && due;
    adv.last   = last_row && out_col_wrap;
    adv.col_ok = {!out_col_wrap, 1'b1, out_col_r != '0};
    adv.row_ok = {!last_row, 1'b1, out_row_r != '0};
    adv.win    = win_step;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    win_nxt     = win_r;
    if (restart || frame_last) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      win_nxt     = '0;
    end else if (step) begin
      win_nxt = win_step;
      if (in_col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (due) begin
        if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
    // narrow frames revisit the column just written; forward it
    byp_nxt = ram_we && (in_col_r == in_col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      win_r     <= '0;
      byp_r     <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      win_r     <= win_nxt;
      byp_r     <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ram_wdata;
  end

endmodule

@@ rtl/bb3_avg.sv @@
// ----------------------------------------------------------------------------
// bb3_avg
// Masked window sums, then rounded division by the neighbour count.
// ----------------------------------------------------------------------------
module bb3_avg (
  input  logic          clk,
  input  logic          rst_n,
  input  bb3_pkg::adv_t adv,
  output logic          s1_free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          out_frame_end
);

  localparam int SB = bb3_pkg::SUM_BITS;
  localparam int PB = SB + bb3_pkg::RECIP_BITS;

  logic [2:0][SB-1:0] sum_r, sum_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               last_r;
  logic               s1_valid_r, s1_valid_nxt;

  logic               out_valid_r;
  logic [2:0][7:0]    out_px_r, quot;
  logic               out_last_r;
  logic               out_free;

  logic [1:0]         ncol, nrow;

  // stage 1: sums over the in-frame neighbours
  always_comb begin
    logic [23:0] v;
    v       = '0;
    sum_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        v = adv.win[c][r];
        if (adv.col_ok[c] && adv.row_ok[r]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_nxt[ch] = sum_nxt[ch] + SB'(v[8*ch +: 8]);
          end
        end
      end
    end
    ncol    = {1'b0, adv.col_ok[0]} + {1'b0, adv.col_ok[1]} + {1'b0, adv.col_ok[2]};
    nrow    = {1'b0, adv.row_ok[0]} + {1'b0, adv.row_ok[1]} + {1'b0, adv.row_ok[2]};
    cnt_nxt = 4'(ncol) * 4'(nrow);
  end

  // stage 2: (sum + cnt/2) / cnt by reciprocal multiply
  always_comb begin
    logic [SB-1:0] rnd;
    logic [PB-1:0] prod;
    rnd  = '0;
    prod = '0;
    for (int ch = 0; ch < 3; ch++) begin
      rnd      = sum_r[ch] + SB'(cnt_r >> 1);
      prod     = PB'(rnd) * PB'(bb3_pkg::recip(cnt_r));
      quot[ch] = prod[bb3_pkg::RECIP_SHIFT +: 8];
    end
  end

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_free  = !s1_valid_r || out_free;
    if (adv.load) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.load) begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= adv.last;
    end
    if (out_free && s1_valid_r) begin
      out_px_r   <= quot;
      out_last_r <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_px_r[2];
  assign out_green     = out_px_r[1];
  assign out_blue      = out_px_r[0];
  assign out_frame_end = out_last_r;

endmodule

@@ rtl/bb3_checker.sv @@
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks for box_blur_3x3, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_req_type,
  input logic [7:0]  in_red,
  input logic [7:0]  in_green,
  input logic [7:0]  in_blue,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_frame_end
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) &&
                               $stable(out_blue) && $stable(out_frame_end))
    else $error("stalled result beat changed");

  // a fresh result follows an accepted input beat, through stage 1 and the output register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a causing input beat");

  // register read-back returns the written value, cut to the register width
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready |=>
      (cfg_paddr[2] != $past(cfg_paddr[2])) ||
      (cfg_prdata == ($past(cfg_paddr[2]) ? ($past(cfg_pwdata) & 32'h1FFF)
                                          : ($past(cfg_pwdata) & 32'h7FF))))
    else $error("register read-back mismatch");

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (.*);
